// ===== hdl/tch_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle circle hit test package
// Shared constants for the triangle versus circle hit test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tch_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int CFG_WIDTH       = 23;
    localparam int RR_WIDTH        = 2 * CFG_WIDTH;
    localparam int CFG_ADDR_WIDTH  = 1;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_RADIUS = 1'b0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_BAND   = 1'b1;

    localparam logic [CFG_WIDTH-1:0] RADIUS_RESET = 23'd59392;
    localparam logic [CFG_WIDTH-1:0] BAND_RESET   = 23'd410;

endpackage

`default_nettype wire

// ===== hdl/tch_mul.sv =====
// ----------------------------------------------------------------------------
// Split multiplier
// Unsigned product in two stages: four half-width partial products, then sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tch_mul #(
    parameter int AW = 34,
    parameter int BW = 34
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [AW-1:0]    i_a,
    input  wire logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0]      o_p
);

    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] r_ll;
    logic [AL+BH-1:0] r_lh;
    logic [AH+BL-1:0] r_hl;
    logic [AH+BH-1:0] r_hh;
    logic [PW-1:0]    r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[AL-1:0] * i_b[BL-1:0];
            r_lh <= i_a[AL-1:0] * i_b[BW-1:BL];
            r_hl <= i_a[AW-1:AL] * i_b[BL-1:0];
            r_hh <= i_a[AW-1:AL] * i_b[BW-1:BL];
            r_p  <= (PW'(r_hh) << (AL + BL)) + (PW'(r_hl) << AL)
                  + (PW'(r_lh) << BL) + PW'(r_ll);
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== hdl/tch_edge.sv =====
// ----------------------------------------------------------------------------
// Edge hit unit
// Decides whether one triangle edge touches the open disc around the origin.
// ----------------------------------------------------------------------------
`default_nettype none

module tch_edge #(
    parameter int COORD_WIDTH = tch_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [COORD_WIDTH-1:0]     i_x1,
    input  wire logic signed [COORD_WIDTH-1:0]     i_y1,
    input  wire logic signed [COORD_WIDTH-1:0]     i_x2,
    input  wire logic signed [COORD_WIDTH-1:0]     i_y2,
    input  wire logic signed [COORD_WIDTH:0]       i_dx,
    input  wire logic signed [COORD_WIDTH:0]       i_dy,
    input  wire logic                              i_degen,
    input  wire logic [tch_pkg::RR_WIDTH-1:0]      i_rr,
    output logic                                   o_hit
);

    localparam int PW  = 2 * COORD_WIDTH + 2;
    localparam int SW  = PW + 1;
    localparam int CMW = SW - 1;
    localparam int RRW = tch_pkg::RR_WIDTH;
    localparam int EW  = (SW > RRW) ? SW : RRW;
    localparam int C2W = 2 * CMW;
    localparam int RLW = RRW + CMW;
    localparam int MW  = (C2W > RLW) ? C2W : RLW;

    logic signed [PW-1:0] r_px2, r_py2, r_qx2, r_qy2, r_dx2, r_dy2;
    logic signed [PW-1:0] r_dxpx, r_dypy, r_pxdy, r_pydx;
    logic signed [SW-1:0] r_r1, r_r2, r_len2, r_d, r_cross;
    logic [3:0]           r_degen;
    logic [1:0]           r_ep;
    logic [1:0]           r_foot;
    logic                 r_hit;
    logic [CMW-1:0]       w_cmag;
    logic signed [SW-1:0] w_cabs;
    logic [C2W-1:0]       w_c2;
    logic [RLW-1:0]       w_rl;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px2  <= i_x1 * i_x1;
            r_py2  <= i_y1 * i_y1;
            r_qx2  <= i_x2 * i_x2;
            r_qy2  <= i_y2 * i_y2;
            r_dx2  <= i_dx * i_dx;
            r_dy2  <= i_dy * i_dy;
            r_dxpx <= i_dx * i_x1;
            r_dypy <= i_dy * i_y1;
            r_pxdy <= i_x1 * i_dy;
            r_pydx <= i_y1 * i_dx;

            r_r1    <= SW'(r_px2) + SW'(r_py2);
            r_r2    <= SW'(r_qx2) + SW'(r_qy2);
            r_len2  <= SW'(r_dx2) + SW'(r_dy2);
            r_d     <= -(SW'(r_dxpx) + SW'(r_dypy));
            r_cross <= SW'(r_pxdy) - SW'(r_pydx);

            r_degen <= {r_degen[2:0], i_degen};
            r_ep    <= {r_ep[0], (EW'(r_r1) < EW'(i_rr)) || (EW'(r_r2) < EW'(i_rr))};
            r_foot  <= {r_foot[0], !r_d[SW-1] && (r_d != '0) && (r_d < r_len2)};

            r_hit <= !r_degen[3] && (r_ep[1] || (r_foot[1] && (MW'(w_c2) < MW'(w_rl))));
        end
    end

    assign w_cabs = r_cross[SW-1] ? -r_cross : r_cross;
    assign w_cmag = w_cabs[CMW-1:0];

    tch_mul #(.AW(CMW), .BW(CMW)) u_cross_sq (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_cmag),
        .i_b   (w_cmag),
        .o_p   (w_c2)
    );

    tch_mul #(.AW(RRW), .BW(CMW)) u_rr_len (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_rr),
        .i_b   (r_len2[CMW-1:0]),
        .o_p   (w_rl)
    );

    assign o_hit = r_hit;

endmodule

`default_nettype wire

// ===== hdl/triangle_circle_hit_test.sv =====
// ----------------------------------------------------------------------------
// Triangle circle hit test
// Flags z band membership and xy disc contact for one triangle per word.
// ----------------------------------------------------------------------------
//  Channel | Signals                                   | Direction
//  in      | i_in_valid, o_in_ready, i_ax .. i_cz      | into block
//  out     | o_out_valid, i_out_ready, o_in_band,      | out of block
//          | o_meets_circle, o_hole_member             |
//  cfg     | i_cfg_we, i_cfg_addr, i_cfg_wdata         | into block
//
// One word per cycle while the output is not held. A result is registered through
// the input stage and the five register stages of the edge units.
// Reset is synchronous, clears the valid bits and loads the two registers with their reset values.
// When the output is held, the whole pipeline holds and o_in_ready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_circle_hit_test #(
    parameter int COORD_WIDTH = tch_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [tch_pkg::CFG_ADDR_WIDTH-1:0]   i_cfg_addr,
    input  wire logic [tch_pkg::CFG_WIDTH-1:0]        i_cfg_wdata,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [COORD_WIDTH-1:0]        i_ax,
    input  wire logic signed [COORD_WIDTH-1:0]        i_ay,
    input  wire logic signed [COORD_WIDTH-1:0]        i_az,
    input  wire logic signed [COORD_WIDTH-1:0]        i_bx,
    input  wire logic signed [COORD_WIDTH-1:0]        i_by_coord,
    input  wire logic signed [COORD_WIDTH-1:0]        i_bz,
    input  wire logic signed [COORD_WIDTH-1:0]        i_cx,
    input  wire logic signed [COORD_WIDTH-1:0]        i_cy,
    input  wire logic signed [COORD_WIDTH-1:0]        i_cz,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic                                      o_in_band,
    output logic                                      o_meets_circle,
    output logic                                      o_hole_member
);

    localparam int W   = COORD_WIDTH;
    localparam int CW  = tch_pkg::CFG_WIDTH;
    localparam int PW  = 2 * W + 2;
    localparam int SW  = PW + 1;
    localparam int ZW  = ((W > CW) ? W : CW) + 2;
    localparam int NST = 6;

    logic [CW-1:0]                 r_radius, r_band;
    logic [tch_pkg::RR_WIDTH-1:0]  r_rr;
    logic [NST-1:0]                r_vld;
    logic                          w_en;

    logic signed [W-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [W:0]   r_abx, r_aby, r_acx, r_acy, r_bcx, r_bcy;
    logic [2:0]          r_degen;
    logic [NST-1:0]      r_inb;

    logic signed [PW-1:0] r_p_det0, r_p_det1, r_p_ds0, r_p_ds1, r_p_dt0, r_p_dt1;
    logic signed [SW-1:0] r_det, r_ds, r_dt;
    logic [2:0]           r_cont;
    logic signed [SW-1:0] w_nd, w_nds, w_ndt;
    logic signed [SW:0]   w_sum;
    logic [2:0]           w_hit;
    logic signed [ZW-1:0] w_band;
    logic [2:0]           w_zok;

    assign w_en        = !r_vld[NST-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= tch_pkg::RADIUS_RESET;
            r_band   <= tch_pkg::BAND_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tch_pkg::REG_RADIUS: r_radius <= i_cfg_wdata;
                tch_pkg::REG_BAND:   r_band   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rr <= r_radius * r_radius;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    assign w_band = ZW'(r_band);
    assign w_zok[0] = (ZW'(i_az) > -w_band) && (ZW'(i_az) < w_band);
    assign w_zok[1] = (ZW'(i_bz) > -w_band) && (ZW'(i_bz) < w_band);
    assign w_zok[2] = (ZW'(i_cz) > -w_band) && (ZW'(i_cz) < w_band);

    assign w_nd  = r_det[SW-1] ? -r_det : r_det;
    assign w_nds = r_det[SW-1] ? -r_ds  : r_ds;
    assign w_ndt = r_det[SW-1] ? -r_dt  : r_dt;
    assign w_sum = (SW+1)'(w_nds) + (SW+1)'(w_ndt);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ax  <= i_ax;
            r_ay  <= i_ay;
            r_bx  <= i_bx;
            r_by  <= i_by_coord;
            r_cx  <= i_cx;
            r_cy  <= i_cy;
            r_abx <= (W+1)'(i_bx) - (W+1)'(i_ax);
            r_aby <= (W+1)'(i_by_coord) - (W+1)'(i_ay);
            r_acx <= (W+1)'(i_cx) - (W+1)'(i_ax);
            r_acy <= (W+1)'(i_cy) - (W+1)'(i_ay);
            r_bcx <= (W+1)'(i_cx) - (W+1)'(i_bx);
            r_bcy <= (W+1)'(i_cy) - (W+1)'(i_by_coord);
            r_degen[0] <= (i_ax == i_bx) && (i_ay == i_by_coord);
            r_degen[1] <= (i_ax == i_cx) && (i_ay == i_cy);
            r_degen[2] <= (i_bx == i_cx) && (i_by_coord == i_cy);
            r_inb <= {r_inb[NST-2:0], &w_zok};

            r_p_det0 <= r_abx * r_acy;
            r_p_det1 <= r_acx * r_aby;
            r_p_ds0  <= r_ay * r_acx;
            r_p_ds1  <= r_ax * r_acy;
            r_p_dt0  <= r_ax * r_aby;
            r_p_dt1  <= r_abx * r_ay;

            r_det <= SW'(r_p_det0) - SW'(r_p_det1);
            r_ds  <= SW'(r_p_ds0) - SW'(r_p_ds1);
            r_dt  <= SW'(r_p_dt0) - SW'(r_p_dt1);

            r_cont <= {r_cont[1:0],
                       !w_ndt[SW-1] && !w_nds[SW-1] && !((SW+1)'(w_nd) < w_sum)};
        end
    end

    tch_edge #(.COORD_WIDTH(W)) u_edge_ab (
        .i_clk(i_clk), .i_en(w_en),
        .i_x1(r_ax), .i_y1(r_ay), .i_x2(r_bx), .i_y2(r_by),
        .i_dx(r_abx), .i_dy(r_aby), .i_degen(r_degen[0]), .i_rr(r_rr),
        .o_hit(w_hit[0])
    );

    tch_edge #(.COORD_WIDTH(W)) u_edge_ac (
        .i_clk(i_clk), .i_en(w_en),
        .i_x1(r_ax), .i_y1(r_ay), .i_x2(r_cx), .i_y2(r_cy),
        .i_dx(r_acx), .i_dy(r_acy), .i_degen(r_degen[1]), .i_rr(r_rr),
        .o_hit(w_hit[1])
    );

    tch_edge #(.COORD_WIDTH(W)) u_edge_bc (
        .i_clk(i_clk), .i_en(w_en),
        .i_x1(r_bx), .i_y1(r_by), .i_x2(r_cx), .i_y2(r_cy),
        .i_dx(r_bcx), .i_dy(r_bcy), .i_degen(r_degen[2]), .i_rr(r_rr),
        .o_hit(w_hit[2])
    );

    assign o_in_band      = r_inb[NST-1];
    assign o_meets_circle = r_cont[2] || (|w_hit);
    assign o_hole_member  = o_in_band && o_meets_circle;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle circle hit test bench
// Streams triangles through the block under random idling on both sides,
// recomputes the band and disc flags exactly in wide signed arithmetic and
// compares every result word against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int CW = tch_pkg::COORD_WIDTH_DEF;
    localparam int DRAIN_CYCLES = 12;

    typedef logic signed [159:0] wide_t;
    typedef logic signed [CW-1:0] coord_t;
    typedef struct {
        coord_t v [9];
    } tri_t;
    typedef struct {
        bit in_band;
        bit meets;
        bit hole;
    } flags_t;

    class hit_scoreboard;
        flags_t pending [$];
        logic [tch_pkg::CFG_WIDTH-1:0] radius = tch_pkg::RADIUS_RESET;
        logic [tch_pkg::CFG_WIDTH-1:0] band = tch_pkg::BAND_RESET;
        int errors = 0;

        function automatic bit edge_hits(wide_t x1, wide_t y1, wide_t x2, wide_t y2,
                                         wide_t rr);
            wide_t dx, dy, len2, d, cr;
            if (x1 == x2 && y1 == y2) return 0;
            dx = x2 - x1;
            dy = y2 - y1;
            if (x1 * x1 + y1 * y1 < rr || x2 * x2 + y2 * y2 < rr) return 1;
            len2 = dx * dx + dy * dy;
            d = -(dx * x1 + dy * y1);
            if (d > 0 && d < len2) begin
                cr = x1 * dy - y1 * dx;
                if (cr * cr < rr * len2) return 1;
            end
            return 0;
        endfunction

        function automatic flags_t hit_flags(tri_t t);
            flags_t f;
            wide_t x1, y1, x2, y2, x3, y3, rr, bw, det, ds, dt;
            x1 = t.v[0]; y1 = t.v[1]; x2 = t.v[3]; y2 = t.v[4]; x3 = t.v[6]; y3 = t.v[7];
            bw = $signed({1'b0, band});
            rr = $signed({1'b0, radius}) * $signed({1'b0, radius});
            f.in_band = 1;
            for (int i = 2; i < 9; i += 3) begin
                if (!(t.v[i] > -bw && t.v[i] < bw)) f.in_band = 0;
            end
            det = (x2 - x1) * (y3 - y1) - (x3 - x1) * (y2 - y1);
            ds = y1 * (x3 - x1) - x1 * (y3 - y1);
            dt = x1 * (y2 - y1) - (x2 - x1) * y1;
            if (det < 0) begin
                det = -det;
                ds = -ds;
                dt = -dt;
            end
            f.meets = (dt >= 0 && ds >= 0 && !(det < ds + dt)) ||
                      edge_hits(x1, y1, x2, y2, rr) || edge_hits(x1, y1, x3, y3, rr) ||
                      edge_hits(x2, y2, x3, y3, rr);
            f.hole = f.in_band && f.meets;
            return f;
        endfunction

        function void note_triangle(tri_t t);
            pending.push_back(hit_flags(t));
        endfunction

        function void check_flags(bit in_band, bit meets, bit hole);
            flags_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result word %0b%0b%0b at %0t",
                                           in_band, meets, hole, $time);
                return;
            end
            e = pending.pop_front();
            if (e.in_band !== in_band || e.meets !== meets || e.hole !== hole) begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch at %0t: in_band %0b/%0b meets %0b/%0b hole %0b/%0b",
                             $time, e.in_band, in_band, e.meets, meets, e.hole, hole);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [tch_pkg::CFG_ADDR_WIDTH-1:0] i_cfg_addr = tch_pkg::REG_RADIUS;
    logic [tch_pkg::CFG_WIDTH-1:0] i_cfg_wdata = '0;
    logic i_in_valid = 0;
    logic o_in_ready;
    coord_t tri_in [9] = '{default: '0};
    logic o_out_valid;
    logic i_out_ready = 0;
    logic o_in_band, o_meets_circle, o_hole_member;

    int send_idle = 0;
    int recv_idle = 0;
    hit_scoreboard sb = new();

    triangle_circle_hit_test #(.COORD_WIDTH(CW)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_ax(tri_in[0]), .i_ay(tri_in[1]), .i_az(tri_in[2]),
        .i_bx(tri_in[3]), .i_by_coord(tri_in[4]), .i_bz(tri_in[5]),
        .i_cx(tri_in[6]), .i_cy(tri_in[7]), .i_cz(tri_in[8]),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_in_band(o_in_band), .o_meets_circle(o_meets_circle),
        .o_hole_member(o_hole_member)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_flags(o_in_band, o_meets_circle, o_hole_member);
    end

    task automatic write_reg(logic [tch_pkg::CFG_ADDR_WIDTH-1:0] idx,
                             logic [tch_pkg::CFG_WIDTH-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == tch_pkg::REG_RADIUS) sb.radius = val;
        else sb.band = val;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic send_triangle(tri_t t);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        for (int i = 0; i < 9; i++) tri_in[i] <= t.v[i];
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_triangle(t);
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic coord_t rnd_coord(int span);
        coord_t extremes [5] = '{{1'b0, {(CW-1){1'b1}}}, {1'b1, {(CW-1){1'b0}}},
                                 coord_t'(0), coord_t'(-1), coord_t'(1)};
        case ($urandom_range(9))
            0, 1: return coord_t'($urandom);
            2: return extremes[$urandom_range(4)];
            default: return coord_t'(int'($urandom_range(2 * span)) - span);
        endcase
    endfunction

    function automatic tri_t rnd_triangle();
        tri_t t;
        int xy_span, z_span;
        xy_span = (sb.radius > 2000000) ? 4000000 : 2 * int'(sb.radius) + 64;
        z_span = (sb.band > 4000000) ? 8000000 : int'(sb.band) + 3;
        for (int i = 0; i < 9; i++) t.v[i] = rnd_coord((i % 3 == 2) ? z_span : xy_span);
        case ($urandom_range(9))
            0: begin t.v[3] = t.v[0]; t.v[4] = t.v[1]; end
            1: begin t.v[6] = t.v[3]; t.v[7] = t.v[4]; end
            2: begin
                t.v[6] = coord_t'(2 * t.v[3] - t.v[0]);
                t.v[7] = coord_t'(2 * t.v[4] - t.v[1]);
            end
            default: ;
        endcase
        return t;
    endfunction

    function automatic tri_t mk(int ax, int ay, int bx, int by_c, int cx, int cy, int z);
        tri_t t;
        t.v = '{coord_t'(ax), coord_t'(ay), coord_t'(z), coord_t'(bx), coord_t'(by_c),
                coord_t'(z), coord_t'(cx), coord_t'(cy), coord_t'(z)};
        return t;
    endfunction

    localparam int CMAX = 8388607;
    localparam int CMIN = -8388608;

    initial begin
        tri_t dir [$];
        tri_t t;
        logic [tch_pkg::CFG_WIDTH-1:0] radius_set [6];
        logic [tch_pkg::CFG_WIDTH-1:0] band_set [6];
        radius_set = '{tch_pkg::RADIUS_RESET, 23'd0, {tch_pkg::CFG_WIDTH{1'b1}},
                       23'($urandom), 23'($urandom_range(200000)), 23'd4096};
        band_set = '{tch_pkg::BAND_RESET, 23'd0, {tch_pkg::CFG_WIDTH{1'b1}},
                     23'($urandom), 23'($urandom_range(5000)), 23'($urandom_range(1000))};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        dir.push_back(mk(0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        dir.push_back(mk(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        dir.push_back(mk(CMIN, CMIN, CMAX, CMIN, 0, CMAX, 0));
        dir.push_back(mk(CMIN, 100, CMAX, 100, CMAX, CMAX, 409));
        dir.push_back(mk(CMIN, 59392, CMAX, 59392, CMAX, CMAX, 410));
        dir.push_back(mk(CMIN, 59391, CMAX, 59391, CMAX, CMAX, -410));
        dir.push_back(mk(1000, 1000, 1000, 1000, 1000, 1000, -409));
        dir.push_back(mk(59392, 0, 59392, 0, 80000, 0, 0));
        dir.push_back(mk(59391, 0, 70000, 0, 80000, 0, 0));
        dir.push_back(mk(-100000, 0, 100000, 0, 200000, 0, 0));
        dir.push_back(mk(100000, 100000, 200000, 100000, 100000, 200000, 0));
        dir.push_back(mk(-100000, -100000, 100000, -100000, 0, 100000, 5));
        dir.push_back(mk(100000, 0, 0, 100000, 100000, 100000, 0));
        dir.push_back(mk(41995, 41995, 41996, 41996, 200000, 41996, 0));
        t = mk(0, 0, 0, 0, 0, 0, 0);
        t.v[2] = coord_t'(CMAX); t.v[5] = coord_t'(CMIN); t.v[8] = coord_t'(409);
        dir.push_back(t);

        for (int p = 0; p < 6; p++) begin
            send_idle = (p < 2) ? 17 : (p < 4) ? 79 : 0;
            recv_idle = (p < 2) ? 79 : (p < 4) ? 17 : 0;
            write_reg(tch_pkg::REG_RADIUS, radius_set[p]);
            write_reg(tch_pkg::REG_BAND, band_set[p]);
            if (p == 0) foreach (dir[i]) send_triangle(dir[i]);
            if (p == 2) foreach (dir[i]) send_triangle(dir[i]);
            for (int n = 0; n < 82; n++) begin
                if (p == 1 && n == 40) drain;
                send_triangle(rnd_triangle());
            end
            drain;
        end

        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/tch_pkg.sv
hdl/tch_mul.sv
hdl/tch_edge.sv
hdl/triangle_circle_hit_test.sv
tb/tb.sv
